@@ hw/rtl/i2cms_pkg.sv @@
// Package for the I2C master transfer sequencer.
// Holds the transaction structs, sequencer state and controller status codes.
// No dependencies; every RTL file of the block imports it.
package i2cms_pkg;

    // Controller status codes
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_W_ADDR_ACK = 8'h18;
    localparam logic [7:0] ST_W_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_R_ADDR_ACK = 8'h40;
    localparam logic [7:0] ST_R_DATA_ACK = 8'h50;
    localparam logic [7:0] ST_R_DATA_NAK = 8'h58;

    // Item kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_EVENT = 1'b1;

    // Completion codes
    localparam logic [1:0] FIN_RUN  = 2'd0;
    localparam logic [1:0] FIN_OK   = 2'd1;
    localparam logic [1:0] FIN_FAIL = 2'd2;

    typedef struct packed {
        logic        func;
        logic [6:0]  target_address;
        logic [7:0]  message_count;
        logic        timeout_flag;
        logic        event_flag;
        logic [7:0]  status_code;
        logic [7:0]  rx_data;
        logic        msg_is_read;
        logic [15:0] msg_length;
        logic [7:0]  tx_byte;
    } t_in_item;

    typedef struct packed {
        logic        write_data_valid;
        logic [7:0]  write_data;
        logic        clear_flag;
        logic        issue_start;
        logic        issue_stop;
        logic        assert_ack;
        logic        store_valid;
        logic [7:0]  store_msg_index;
        logic [15:0] store_byte_index;
        logic [1:0]  finish_status;
        logic [7:0]  next_msg_index;
        logic [15:0] next_byte_index;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [7:0]  total_messages;
        logic [7:0]  message_index;
        logic [15:0] byte_index;
    } t_seq_state;

endpackage

@@ hw/rtl/i2cms_step.sv @@
// Status decode for one sequencer transaction: result fields and next state.
// Pure combinational logic; depends on i2cms_pkg.
module i2cms_step import i2cms_pkg::*; (
    input  t_in_item   i_item,
    input  t_seq_state i_state,
    output t_out_item  o_result,
    output t_seq_state o_state
);

    logic        in_range;
    logic [16:0] bidx_inc;
    logic [16:0] bidx_after;
    logic [7:0]  midx_inc;
    logic        more_msgs;

    // Byte index and message index arithmetic shared by the decode arms
    assign in_range   = (i_state.byte_index < i_item.msg_length);
    assign bidx_inc   = {1'b0, i_state.byte_index} + 17'd1;
    assign bidx_after = in_range ? bidx_inc : {1'b0, i_state.byte_index};
    assign midx_inc   = i_state.message_index + 8'd1;
    assign more_msgs  = (midx_inc < i_state.total_messages);

    always_comb begin
        logic fail;
        logic do_store;
        logic do_advance;
        fail       = 1'b0;
        do_store   = 1'b0;
        do_advance = 1'b0;
        o_result   = '0;
        o_state    = i_state;

        if (i_item.func == FUNC_START) begin
            if (i_item.message_count == 8'd0) begin
                o_result.finish_status = FIN_FAIL;
            end else begin
                o_state.device_address = i_item.target_address;
                o_state.total_messages = i_item.message_count;
                o_state.message_index  = '0;
                o_state.byte_index     = '0;
                o_result.issue_start   = 1'b1;
            end
        end else if (i_item.timeout_flag) begin
            fail = 1'b1;
        end else if (i_item.event_flag) begin
            if (i_item.msg_is_read) begin
                case (i_item.status_code)
                    ST_START, ST_RESTART: begin
                        o_result.write_data_valid = 1'b1;
                        o_result.write_data       = {i_state.device_address, 1'b1};
                        o_result.clear_flag       = 1'b1;
                    end
                    ST_R_ADDR_ACK: begin
                        if (i_item.msg_length > 16'd1) begin
                            o_result.clear_flag = 1'b1;
                            o_result.assert_ack = 1'b1;
                        end else if (i_item.msg_length == 16'd1) begin
                            o_result.clear_flag = 1'b1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    ST_R_DATA_ACK: begin
                        do_store            = 1'b1;
                        o_result.clear_flag = 1'b1;
                        o_result.assert_ack = ((bidx_after + 17'd1) < {1'b0, i_item.msg_length});
                    end
                    ST_R_DATA_NAK: begin
                        do_store   = 1'b1;
                        do_advance = 1'b1;
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
            end else begin
                case (i_item.status_code)
                    ST_START, ST_RESTART: begin
                        o_result.write_data_valid = 1'b1;
                        o_result.write_data       = {i_state.device_address, 1'b0};
                        o_result.clear_flag       = 1'b1;
                    end
                    ST_W_ADDR_ACK, ST_W_DATA_ACK: begin
                        if (in_range) begin
                            o_result.write_data_valid = 1'b1;
                            o_result.write_data       = i_item.tx_byte;
                            o_result.clear_flag       = 1'b1;
                            o_state.byte_index        = bidx_inc[15:0];
                        end else begin
                            do_advance = 1'b1;
                        end
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
            end
        end

        // Store the received byte at the current position, then step the byte index
        if (do_store && in_range) begin
            o_result.store_valid      = 1'b1;
            o_result.store_msg_index  = i_state.message_index;
            o_result.store_byte_index = i_state.byte_index;
            o_state.byte_index        = bidx_inc[15:0];
        end

        // Move to the next message: repeated START, or STOP when all are done
        if (do_advance) begin
            o_state.message_index = midx_inc;
            o_result.clear_flag   = 1'b1;
            if (more_msgs) begin
                o_state.byte_index   = '0;
                o_result.issue_start = 1'b1;
            end else begin
                o_result.issue_stop    = 1'b1;
                o_result.finish_status = FIN_OK;
            end
        end

        // Fail paths never follow a state change; drop everything and stop the bus
        if (fail) begin
            o_result               = '0;
            o_result.clear_flag    = 1'b1;
            o_result.issue_stop    = 1'b1;
            o_result.finish_status = FIN_FAIL;
            o_state                = i_state;
        end

        o_result.next_msg_index  = o_state.message_index;
        o_result.next_byte_index = o_state.byte_index;
    end

endmodule

@@ hw/rtl/i2c_master_transfer_sequencer_core.sv @@
// Top level of the I2C master transfer sequencer.
// Input register, status decode (i2cms_step) and result register; uses i2cms_pkg.
//
// Usage:
//   Input channel (i_in_valid / i_in_item / o_in_stall) carries one transaction
//   per controller event or per new transfer request. func = FUNC_START latches
//   the target address and message count and asks for START (a zero count fails); func = FUNC_EVENT
//   passes the controller flags, status code and the current message's
//   direction, length and transmit byte.
//   Output channel (o_out_valid / o_out_item / i_out_stall) returns exactly one
//   result transaction per input transaction, in order: data register load,
//   clear / START / STOP / ACK requests, where to store a received byte,
//   completion status and the updated message and byte indices.
// Path: an accepted transaction lands in the input register, is decoded and
//   captured in the result register when that is free, then offered on the output.
// Throughput: one transaction per cycle unless the receiver stalls. The decode
//   is one short combinational pass over the input register and the four state
//   registers; the sequencer state is updated in the same edge that loads the
//   result register.
// Stall: when the receiver stalls, the result register holds; the input
//   register then holds too and o_in_stall rises only while it is full.
// Reset: i_rst_n low (synchronous) empties both registers and clears the
//   device address, message count and both indices.
module i2c_master_transfer_sequencer_core import i2cms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_seq_state r_state;

    t_out_item  n_out_item;
    t_seq_state n_state;

    logic out_free;
    logic step_fire;
    logic in_fire;

    // Result register takes a new transaction when empty or being drained
    assign out_free  = !r_out_valid || !i_out_stall;
    assign step_fire = r_in_valid && out_free;
    assign in_fire   = i_in_valid && !o_in_stall;

    // Stall the sender only while the input register holds an item that cannot move
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    i2cms_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_result (n_out_item),
        .o_state  (n_state)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register and sequencer state advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_item <= n_out_item;
        end
    end

    // Sequencer state moves only when a transaction is decoded
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step_fire |=> $stable(r_state))
        else $error("sequencer state changed without a decoded transaction");

    // Reported indices always match the state they leave behind
    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire |=> (r_out_item.next_msg_index == r_state.message_index &&
                       r_out_item.next_byte_index == r_state.byte_index))
        else $error("reported indices disagree with sequencer state");

    // START and STOP are never requested together
    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.issue_start && r_out_item.issue_stop))
        else $error("START and STOP requested in one result");

    // A stored byte never coincides with a data register load
    a_store_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.store_valid) |-> !r_out_item.write_data_valid)
        else $error("store and data load in one result");

    // Finish code is one of the defined completion codes
    a_finish_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.finish_status == FIN_RUN ||
                         r_out_item.finish_status == FIN_OK ||
                         r_out_item.finish_status == FIN_FAIL))
        else $error("undefined finish status");

    // Input register cannot be stalled while empty
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled while input register empty");

endmodule
